>>> src/mfbp_pkg.sv
// shared constants and types for the msb-first bit packer
`default_nettype none
package mfbp_pkg;

  localparam int BYTE_BITS = 8;
  localparam int PEND_BITS = BYTE_BITS - 1;
  localparam int IN_VALUE_BITS = 32;
  localparam int IN_LEN_BITS = 6;

  typedef logic [BYTE_BITS-1:0] byte_t;

  // handshake between the queue and the back end
  typedef struct packed {
    logic valid;
    logic ready;
  } q_hs_t;

endpackage
`default_nettype wire

>>> src/mfbp_front.sv
// front end: clamps the length and left-aligns the field bits of a request
`default_nettype none
module mfbp_front #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int LEN_BITS = $clog2(MAX_FIELD_BITS + 1)
) (
  input  wire logic [mfbp_pkg::IN_VALUE_BITS-1:0] field_value,
  input  wire logic [mfbp_pkg::IN_LEN_BITS-1:0]   field_length,
  output logic [MAX_FIELD_BITS-1:0]                value_left,
  output logic [LEN_BITS-1:0]                      len_sat
);

  logic [MAX_FIELD_BITS-1:0] val_ext;
  logic [LEN_BITS-1:0]       shift_amt;

  always_comb begin
    if (int'(field_length) > MAX_FIELD_BITS) begin
      len_sat = LEN_BITS'(MAX_FIELD_BITS);
    end else begin
      len_sat = LEN_BITS'(field_length);
    end
  end

  // bits above the length fall off the top
  assign val_ext    = MAX_FIELD_BITS'(field_value);
  assign shift_amt  = LEN_BITS'(MAX_FIELD_BITS) - len_sat;
  assign value_left = val_ext << shift_amt;

endmodule
`default_nettype wire

>>> src/mfbp_queue.sv
// two-entry queue between front end and back end
`default_nettype none
module mfbp_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  output mfbp_pkg::q_hs_t       hs_out,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full         = (count == 2'd2);
  assign hs_out.valid = (count != 2'd0);
  assign hs_out.ready = rd_ready;
  assign do_wr        = wr_en && !full;
  assign do_rd        = hs_out.valid && rd_ready;
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule
`default_nettype wire

>>> src/mfbp_back.sv
// back end: bit accumulator; one byte a cycle into the output register unless stalled
`default_nettype none
module mfbp_back #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int LEN_BITS = $clog2(MAX_FIELD_BITS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mfbp_pkg::q_hs_t           hs_in,
  output logic                           rd_ready,
  input  wire logic [MAX_FIELD_BITS-1:0] value_left,
  input  wire logic [LEN_BITS-1:0]       len,
  input  wire logic                      eom,
  output logic                           empty,
  input  wire logic                      pop,
  output mfbp_pkg::byte_t                out_byte,
  output logic                           last_byte
);

  localparam int W  = MAX_FIELD_BITS + mfbp_pkg::PEND_BITS;
  localparam int RW = $clog2(W + 1);

  logic [W-1:0]    acc, acc_b, acc_next;
  logic [RW-1:0]   rem, rem_b, rem_next;
  logic            eom_f, eom_b, eom_next;
  logic            ovalid;
  logic            can_out;
  logic            emit_full;
  logic            emit_pad;
  logic            flush;
  logic            load;
  logic            last_new;
  logic            rem_ge8;

  assign can_out = !ovalid || pop;
  assign rem_ge8 = (rem >= RW'(mfbp_pkg::BYTE_BITS));

  always_comb begin
    emit_full = rem_ge8 && can_out;
    emit_pad  = !rem_ge8 && eom_f && (rem != '0) && can_out;
    flush     = !rem_ge8 && eom_f && ((rem == '0) || can_out);
    last_new  = emit_full ? (eom_f && (rem == RW'(mfbp_pkg::BYTE_BITS))) : 1'b1;

    acc_b = acc;
    rem_b = rem;
    eom_b = eom_f;
    if (emit_full) begin
      acc_b = acc << mfbp_pkg::BYTE_BITS;
      rem_b = rem - RW'(mfbp_pkg::BYTE_BITS);
      eom_b = eom_f && !last_new;
    end else if (flush) begin
      acc_b = '0;
      rem_b = '0;
      eom_b = 1'b0;
    end

    // merge the next field behind whatever bits are still pending
    load     = hs_in.valid && (rem_b < RW'(mfbp_pkg::BYTE_BITS)) && !eom_b;
    acc_next = acc_b;
    rem_next = rem_b;
    eom_next = eom_b;
    if (load) begin
      acc_next = acc_b | ({value_left, {mfbp_pkg::PEND_BITS{1'b0}}} >> rem_b[2:0]);
      rem_next = rem_b + RW'(len);
      eom_next = eom;
    end
  end

  assign rd_ready = load;
  assign empty    = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      rem    <= '0;
      eom_f  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      acc   <= acc_next;
      rem   <= rem_next;
      eom_f <= eom_next;
      if (emit_full || emit_pad) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_full || emit_pad) begin
      out_byte  <= acc[W-1 -: mfbp_pkg::BYTE_BITS];
      last_byte <= last_new;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst) rem <= RW'(W))
    else $error("bit count out of range");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !pop) |=> (ovalid && $stable(out_byte) && $stable(last_byte)))
    else $error("waiting result lost");

  a_clean_after_last: assert property (@(posedge clk) disable iff (rst)
    ((emit_full || emit_pad) && last_new && !load) |=> (rem == '0 && !eom_f))
    else $error("state not cleared after last byte");

  a_no_load_full: assert property (@(posedge clk) disable iff (rst)
    (rem_ge8 && !can_out) |-> !load)
    else $error("field merged while a byte is pending");

endmodule
`default_nettype wire

>>> src/msb_first_bit_packer_unit.sv
// top level of the msb-first variable-length bit packer
//
//  channel   direction  handshake            payload
//  request   in         push / full          field_value, field_length, end_of_message
//  result    out        pop / empty          out_byte, last_byte
//
// a field of n bits with p bits pending gives floor((n + p) / 8) bytes, one a cycle
// when not stalled, plus a padded byte on end of message if any bits remain.
// the byte-wide output register of the back end sets the rate; requests wait in a
// two-entry queue while it drains. synchronous reset clears pending bits and the queue.
// a stalled result holds the output register; the queue keeps taking requests until full.
`default_nettype none
module msb_first_bit_packer_unit #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [mfbp_pkg::IN_VALUE_BITS-1:0]  field_value,
  input  wire logic [mfbp_pkg::IN_LEN_BITS-1:0]    field_length,
  input  wire logic                                end_of_message,
  output logic                                     empty,
  input  wire logic                                pop,
  output mfbp_pkg::byte_t                          out_byte,
  output logic                                     last_byte
);

  localparam int LEN_BITS = $clog2(MAX_FIELD_BITS + 1);
  localparam int Q_WIDTH  = MAX_FIELD_BITS + LEN_BITS + 1;

  logic [MAX_FIELD_BITS-1:0] f_value;
  logic [LEN_BITS-1:0]       f_len;
  logic [Q_WIDTH-1:0]        q_rd_data;
  mfbp_pkg::q_hs_t           q_hs;
  logic                      rd_ready;

  mfbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .LEN_BITS(LEN_BITS)
  ) u_front (
    .field_value (field_value),
    .field_length(field_length),
    .value_left  (f_value),
    .len_sat     (f_len)
  );

  mfbp_queue #(
    .WIDTH(Q_WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({f_value, f_len, end_of_message}),
    .full    (full),
    .hs_out  (q_hs),
    .rd_ready(rd_ready),
    .rd_data (q_rd_data)
  );

  mfbp_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .LEN_BITS(LEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .hs_in     (q_hs),
    .rd_ready  (rd_ready),
    .value_left(q_rd_data[Q_WIDTH-1 -: MAX_FIELD_BITS]),
    .len       (q_rd_data[LEN_BITS:1]),
    .eom       (q_rd_data[0]),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the msb-first variable-length bit packer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 357;
  localparam int TAIL_CYCLES = 20;

  typedef logic [mfbp_pkg::IN_LEN_BITS-1:0] len_t;

  typedef struct packed {
    mfbp_pkg::byte_t data;
    logic last;
  } byte_rec_t;

  typedef struct packed {
    logic typed;
    logic [2:0] n;
    logic [39:0] bytes;
  } golden_t;

  typedef struct packed {
    logic [mfbp_pkg::IN_VALUE_BITS-1:0] value;
    logic [mfbp_pkg::IN_LEN_BITS-1:0] len;
    logic eom;
    golden_t gold;
  } stim_row_t;

  localparam golden_t PREDICT = '0;
  localparam int DIR_ROWS = 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [mfbp_pkg::IN_VALUE_BITS-1:0] field_value = '0;
  logic [mfbp_pkg::IN_LEN_BITS-1:0] field_length = '0;
  logic end_of_message = 1'b0;
  logic empty;
  logic pop = 1'b0;
  mfbp_pkg::byte_t out_byte;
  logic last_byte;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{32'h0000_00A5, 6'd8, 1'b1, '{1'b1, 3'd1, 40'hA5_0000_0000}},
    '{32'hFFFF_FFFF, 6'd32, 1'b1, '{1'b1, 3'd4, 40'hFFFF_FFFF_00}},
    '{32'hDEAD_BEEF, 6'd32, 1'b1, '{1'b1, 3'd4, 40'hDEAD_BEEF_00}},
    '{32'h0000_0001, 6'd1, 1'b1, '{1'b1, 3'd1, 40'h80_0000_0000}},
    '{32'h0000_0000, 6'd0, 1'b1, '{1'b1, 3'd0, 40'h0}},
    '{32'hFFFF_FFFF, 6'd0, 1'b0, '{1'b1, 3'd0, 40'h0}},
    '{32'hFFFF_FF03, 6'd2, 1'b1, '{1'b1, 3'd1, 40'hC0_0000_0000}},
    '{32'h1234_5678, 6'd63, 1'b1, '{1'b1, 3'd4, 40'h1234_5678_00}},
    '{32'hAAAA_AAAA, 6'd33, 1'b1, '{1'b1, 3'd4, 40'hAAAA_AAAA_00}},
    '{32'h0000_0005, 6'd3, 1'b0, '{1'b1, 3'd0, 40'h0}},
    '{32'h0000_001F, 6'd5, 1'b0, '{1'b1, 3'd1, 40'hBF_0000_0000}},
    '{32'h0000_007F, 6'd7, 1'b0, '{1'b1, 3'd0, 40'h0}},
    '{32'h0000_0000, 6'd0, 1'b1, '{1'b1, 3'd1, 40'hFE_0000_0000}},
    '{32'h0000_0003, 6'd2, 1'b0, PREDICT},
    '{32'hFFFF_FFFF, 6'd32, 1'b0, PREDICT},
    '{32'h0000_0000, 6'd32, 1'b1, PREDICT},
    '{32'h0000_0007, 6'd3, 1'b0, PREDICT},
    '{32'h0000_001F, 6'd5, 1'b1, PREDICT},
    '{32'h8000_0000, 6'd32, 1'b0, PREDICT},
    '{32'h0000_0001, 6'd1, 1'b1, PREDICT},
    '{32'h0000_0000, 6'd0, 1'b0, PREDICT},
    '{32'h0000_0000, 6'd6, 1'b0, PREDICT},
    '{32'h0000_0001, 6'd63, 1'b1, PREDICT}
  };

  byte_rec_t due_bytes[$];
  byte_rec_t step_bytes[$];
  golden_t golden_q[$];
  logic [mfbp_pkg::PEND_BITS-1:0] held_bits = '0;
  logic [2:0] held_count = '0;
  int mismatch_count = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int stall_left = 0;

  msb_first_bit_packer_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .field_value(field_value),
    .field_length(field_length),
    .end_of_message(end_of_message),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last_byte(last_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

  // appends a field to the held bits, collects completed bytes, pads on eom
  function automatic void pack_field(input logic [mfbp_pkg::IN_VALUE_BITS-1:0] value,
                                     input logic [mfbp_pkg::IN_LEN_BITS-1:0] len,
                                     input logic eom);
    mfbp_pkg::byte_t cur;
    int cnt;
    int eff_len;
    byte_rec_t rec;
    step_bytes.delete();
    cur = {1'b0, held_bits};
    cnt = int'(held_count);
    eff_len = (int'(len) > mfbp_pkg::IN_VALUE_BITS) ? mfbp_pkg::IN_VALUE_BITS : int'(len);
    for (int i = eff_len - 1; i >= 0; i--) begin
      cur = {cur[mfbp_pkg::BYTE_BITS-2:0], value[i]};
      cnt++;
      if (cnt == mfbp_pkg::BYTE_BITS) begin
        rec.data = cur;
        rec.last = 1'b0;
        step_bytes.push_back(rec);
        cur = '0;
        cnt = 0;
      end
    end
    if (eom) begin
      if (cnt != 0) begin
        rec.data = cur << (mfbp_pkg::BYTE_BITS - cnt);
        rec.last = 1'b1;
        step_bytes.push_back(rec);
      end else if (step_bytes.size() > 0) begin
        step_bytes[step_bytes.size()-1].last = 1'b1;
      end
      cur = '0;
      cnt = 0;
    end
    held_bits = cur[mfbp_pkg::PEND_BITS-1:0];
    held_count = cnt[2:0];
  endfunction

  // check results, then predict for the request taken at this edge
  always @(posedge clk) begin
    byte_rec_t want;
    byte_rec_t rec;
    golden_t g;
    if (!rst) begin
      if (pop && !empty) begin
        if (due_bytes.size() == 0) begin
          $error("unexpected byte: out_byte=0x%02h last_byte=%0b", out_byte, last_byte);
          mismatch_count++;
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_byte);
            mismatch_count++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, last_byte);
            mismatch_count++;
          end
        end
      end
      if (push && !full) begin
        g = golden_q.pop_front();
        pack_field(field_value, field_length, end_of_message);
        if (g.typed) begin
          for (int k = 0; k < g.n; k++) begin
            rec.data = g.bytes[39-8*k -: 8];
            rec.last = end_of_message && (k == g.n - 1);
            due_bytes.push_back(rec);
          end
        end else begin
          foreach (step_bytes[k]) due_bytes.push_back(step_bytes[k]);
        end
      end
    end
  end

  // result side pops under one of three randomly chosen stall patterns
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: begin
          pop <= 1'b1;
        end
        1: begin
          pop <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  task automatic send_request(input logic [mfbp_pkg::IN_VALUE_BITS-1:0] value,
                              input logic [mfbp_pkg::IN_LEN_BITS-1:0] len, input logic eom,
                              input golden_t gold);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    golden_q.push_back(gold);
    push <= 1'b1;
    field_value <= value;
    field_length <= len;
    end_of_message <= eom;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (golden_q.size() != 0 || due_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int counted;
    int msgs;
    int nfields;
    int r;
    logic broken;
    logic eom;
    len_t len;
    counted = 0;
    msgs = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_request(dir_rows[k].value, dir_rows[k].len, dir_rows[k].eom, dir_rows[k].gold);
    end
    drain_results();

    while (counted < RANDOM_ITEMS) begin
      nfields = $urandom_range(1, 8);
      broken = ($urandom_range(0, 9) == 0);
      for (int f = 0; f < nfields; f++) begin
        r = $urandom_range(0, 19);
        if (r == 0) len = '0;
        else if (r == 1) len = len_t'($urandom_range(33, 63));
        else if (r <= 4) len = len_t'(32);
        else len = len_t'($urandom_range(1, 31));
        eom = broken ? 1'($urandom_range(0, 1)) : (f == nfields - 1);
        if (len != '0 || eom) counted++;
        send_request($urandom, len, eom, PREDICT);
      end
      msgs++;
      if (msgs == 25) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
